>>> design/h264rtp_pkg.sv
// Shared types, constants and register codes of the H.264 RTP packet planner.
package h264rtp_pkg;

   localparam int LEN_W        = 14;
   localparam int MP_W         = 13;
   localparam int RED_W        = 7;
   localparam int DIV_W        = 15;
   localparam int PKT_MAX      = 64;
   localparam int PKT_DEFAULT  = 64;
   localparam int CNT_W        = $clog2(PKT_MAX + 1);
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int QUEUE_DEPTH  = 2;
   localparam int FU_OVERHEAD  = 2;
   localparam logic [7:0] FU_A_TYPE = 8'd28;

   localparam logic [MP_W-1:0]  MAX_PAYLOAD_RESET    = 13'd1200;
   localparam logic [RED_W-1:0] LAST_REDUCTION_RESET = 7'd0;
   localparam logic             MODE_RESET           = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_REDUCTION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE           = 2'd2;

   typedef enum logic [1:0] {
      KIND_SINGLE = 2'd0,
      KIND_FU_A   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [MP_W-1:0]  max_payload;
      logic [RED_W-1:0] last_reduction;
      logic             mode_non_interleaved;
   } cfg_type;

   // One planned NAL unit handed from the classifier to the emitter.
   typedef struct packed {
      kind_type         kind;
      logic [LEN_W-1:0] nal_length;
      logic [LEN_W-1:0] pl;
      logic [DIV_W-1:0] per;
      logic [CNT_W-1:0] larger;
      logic [CNT_W-1:0] num;
      logic [7:0]       ind;
      logic [4:0]       typ;
      logic             fend;
   } job_type;

   typedef struct packed {
      kind_type         kind;
      logic [LEN_W-1:0] slice_offset;
      logic [LEN_W-1:0] slice_length;
      logic [7:0]       fu_ind_byte;
      logic [7:0]       fu_header_byte;
      logic             marker;
      logic             last_of_run;
   } result_type;

endpackage

>>> design/h264rtp_if.sv
// Handshake channel interfaces for NAL descriptors, packet descriptors and register writes.
interface h264rtp_req_if import h264rtp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] nal_length;
   logic [7:0]       nal_header;
   logic             frame_end;
   modport source (output valid, nal_length, nal_header, frame_end, input ready);
   modport sink   (input valid, nal_length, nal_header, frame_end, output ready);
endinterface

interface h264rtp_rsp_if import h264rtp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       kind;
   logic [LEN_W-1:0] slice_offset;
   logic [LEN_W-1:0] slice_length;
   logic [7:0]       fu_ind_byte;
   logic [7:0]       fu_header_byte;
   logic             marker;
   logic             last_of_run;
   modport source (output valid, kind, slice_offset, slice_length, fu_ind_byte,
                   fu_header_byte, marker, last_of_run, input ready);
   modport sink   (input valid, kind, slice_offset, slice_length, fu_ind_byte,
                   fu_header_byte, marker, last_of_run, output ready);
endinterface

interface h264rtp_csr_if import h264rtp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/h264_rtp_packet_planner.sv
// Top level of the H.264 RTP packet planner: registers, classifier, queue and emitter.
// A fitting NAL unit or an immediate error passes the classifier register, the queue and
// the emitter register; an error for too many fragments waits for the first division, and
// the first packet of a fragmented NAL unit for both divisions. The classifier takes a new
// NAL unit once the last was queued or dropped; the emitter sends one descriptor per cycle
// while the receiver is ready. Synchronous reset clears all control state.
module h264_rtp_packet_planner import h264rtp_pkg::*; #(
   parameter int MAX_PACKETS_PER_NAL = PKT_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   h264rtp_req_if.sink   req_chan,
   h264rtp_rsp_if.source rsp_chan,
   h264rtp_csr_if.sink   csr_chan
);

   cfg_type cfg_ff;
   job_type front_job;
   logic    front_valid;
   logic    q_full;
   logic    q_push;
   job_type q_head;
   logic    q_not_empty;
   logic    q_pop;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_payload          <= MAX_PAYLOAD_RESET;
         cfg_ff.last_reduction       <= LAST_REDUCTION_RESET;
         cfg_ff.mode_non_interleaved <= MODE_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_MAX_PAYLOAD:    cfg_ff.max_payload <= csr_chan.data[MP_W-1:0];
            CSR_LAST_REDUCTION: cfg_ff.last_reduction <= csr_chan.data[RED_W-1:0];
            CSR_MODE:           cfg_ff.mode_non_interleaved <= csr_chan.data[0];
            default:            cfg_ff <= cfg_ff;
         endcase
      end
   end

   h264rtp_front #(.MAX_PACKETS(MAX_PACKETS_PER_NAL)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cfg       (cfg_ff),
      .job       (front_job),
      .job_valid (front_valid),
      .job_ready (!q_full)
   );

   assign q_push = front_valid && !q_full;

   h264rtp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (front_job),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .not_empty (q_not_empty)
   );

   h264rtp_back #(.MAX_PACKETS(MAX_PACKETS_PER_NAL)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (q_head),
      .job_valid (q_not_empty),
      .job_pop   (q_pop),
      .rsp       (rsp_chan)
   );

   // The emitter never takes a job from an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_not_empty)
      else $error("job popped from empty queue");

   // A frame marker is only set on the last packet of a NAL unit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.marker |-> rsp_chan.last_of_run)
      else $error("marker on a packet that does not end its NAL unit");

   // FU-A slices start after the NAL header byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.kind == KIND_FU_A |-> rsp_chan.slice_offset != '0)
      else $error("FU-A slice starts at the NAL header");

   // An error result is never followed by more packets of the same NAL unit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.kind == KIND_ERROR |-> rsp_chan.last_of_run)
      else $error("error result not closing its run");

endmodule

>>> design/h264rtp_div.sv
// Restoring divider producing one quotient bit per cycle.
module h264rtp_div import h264rtp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient,
   output logic [DIV_W-1:0] remainder
);

   localparam int STEP_W = $clog2(DIV_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dsr_ff, dsr_in;
   logic [DIV_W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> design/h264rtp_front.sv
// Classifier: accepts NAL descriptors, decides single, error or FU-A, and sizes fragments.
module h264rtp_front import h264rtp_pkg::*; #(
   parameter int MAX_PACKETS = PKT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   h264rtp_req_if.sink        req,
   input  cfg_type            cfg,
   output job_type            job,
   output logic               job_valid,
   input  logic               job_ready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_NUM,
      ST_DIV_PER,
      ST_PUSH
   } state_type;

   state_type        state_ff;
   job_type          job_ff;
   logic             dropped_ff;
   logic [DIV_W-1:0] total_ff;
   logic [LEN_W-1:0] pl_ff;
   logic [7:0]       hdr_ff;
   logic             fend_ff;
   logic [CNT_W-1:0] num_ff;

   logic             accept;
   logic [RED_W-1:0] extra;
   logic [DIV_W-1:0] need;
   logic             fits;
   logic [MP_W-1:0]  cap;
   logic [LEN_W-1:0] pl;
   logic [DIV_W-1:0] total;
   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic [DIV_W-1:0] div_divisor;
   logic             div_done;
   logic [DIV_W-1:0] div_quo;
   logic [DIV_W-1:0] div_rem;
   logic             too_many;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;

   always_comb begin
      extra = req.frame_end ? cfg.last_reduction : '0;
      need  = DIV_W'(req.nal_length) + DIV_W'(extra);
      fits  = need <= DIV_W'(cfg.max_payload);
      cap   = (cfg.max_payload > MP_W'(FU_OVERHEAD)) ?
              cfg.max_payload - MP_W'(FU_OVERHEAD) : '0;
      pl    = (req.nal_length > LEN_W'(1)) ? req.nal_length - 1'b1 : '0;
      total = DIV_W'(pl) + DIV_W'(extra);
   end

   assign too_many = div_quo > DIV_W'(MAX_PACKETS);

   // The first division rounds up: (total + cap - 1) / cap.
   assign div_start = (accept && !dropped_ff && !fits && cfg.mode_non_interleaved &&
                       cap != '0 && pl != '0) ||
                      (state_ff == ST_DIV_NUM && div_done && !too_many);
   assign div_dividend = (state_ff == ST_IDLE) ?
                         DIV_W'(total + DIV_W'(cap) - 1'b1) : total_ff;
   assign div_divisor  = (state_ff == ST_IDLE) ? DIV_W'(cap) : div_quo;

   h264rtp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         dropped_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  total_ff <= total;
                  pl_ff    <= pl;
                  hdr_ff   <= req.nal_header;
                  fend_ff  <= req.frame_end;
                  if (dropped_ff) begin
                     if (req.frame_end) begin
                        dropped_ff <= 1'b0;
                     end
                  end else if (fits) begin
                     job_ff.kind       <= KIND_SINGLE;
                     job_ff.nal_length <= req.nal_length;
                     job_ff.fend       <= req.frame_end;
                     state_ff          <= ST_PUSH;
                  end else if (!cfg.mode_non_interleaved || cap == '0 || pl == '0) begin
                     job_ff.kind <= KIND_ERROR;
                     dropped_ff  <= !req.frame_end;
                     state_ff    <= ST_PUSH;
                  end else begin
                     state_ff <= ST_DIV_NUM;
                  end
               end
            end
            ST_DIV_NUM: begin
               if (div_done) begin
                  if (too_many) begin
                     job_ff.kind <= KIND_ERROR;
                     dropped_ff  <= !fend_ff;
                     state_ff    <= ST_PUSH;
                  end else begin
                     num_ff   <= div_quo[CNT_W-1:0];
                     state_ff <= ST_DIV_PER;
                  end
               end
            end
            ST_DIV_PER: begin
               if (div_done) begin
                  job_ff.kind   <= KIND_FU_A;
                  job_ff.pl     <= pl_ff;
                  job_ff.per    <= div_quo;
                  job_ff.larger <= div_rem[CNT_W-1:0];
                  job_ff.num    <= num_ff;
                  job_ff.ind    <= (hdr_ff & 8'hE0) | FU_A_TYPE;
                  job_ff.typ    <= hdr_ff[4:0];
                  job_ff.fend   <= fend_ff;
                  state_ff      <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (job_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign job       = job_ff;
   assign job_valid = (state_ff == ST_PUSH);

endmodule

>>> design/h264rtp_queue.sv
// Small FIFO of planned NAL units between the classifier and the emitter.
module h264rtp_queue import h264rtp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head,
   output logic    not_empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   job_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff;
   logic [PTR_W-1:0]  rd_ff;
   logic [FILL_W-1:0] fill_ff;

   assign full      = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
      if (push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

endmodule

>>> design/h264rtp_back.sv
// Emitter: turns planned NAL units into packet descriptors, one per cycle while the receiver is ready.
module h264rtp_back import h264rtp_pkg::*; #(
   parameter int MAX_PACKETS = PKT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  job_type     job,
   input  logic        job_valid,
   output logic        job_pop,
   h264rtp_rsp_if.source rsp
);

   logic             busy_ff;
   logic             out_valid_ff;
   result_type       out_ff;
   logic [LEN_W-1:0] pl_ff;
   logic [DIV_W-1:0] per_ff;
   logic [CNT_W-1:0] larger_ff;
   logic [CNT_W-1:0] num_ff;
   logic [CNT_W-1:0] k_ff;
   logic [LEN_W-1:0] off_ff;
   logic [7:0]       ind_ff;
   logic [4:0]       typ_ff;
   logic             fend_ff;

   logic             load_ok;
   logic             step;
   logic [DIV_W-1:0] per_eff;
   logic [LEN_W-1:0] plen;
   logic             is_last;
   logic [LEN_W-1:0] pl_next;
   logic [CNT_W-1:0] k_next;
   result_type       frag;
   result_type       whole;

   assign load_ok = !out_valid_ff || rsp.ready;
   assign job_pop = !busy_ff && job_valid && load_ok;
   assign step    = busy_ff && load_ok;

   // One FU-A fragment; the extra byte moves to the packets counted by the remainder.
   always_comb begin
      per_eff = (num_ff == larger_ff) ? per_ff + 1'b1 : per_ff;
      if (DIV_W'(pl_ff) <= per_eff) begin
         plen = (num_ff == CNT_W'(2)) ? pl_ff - 1'b1 : pl_ff;
      end else begin
         plen = per_eff[LEN_W-1:0];
      end
      is_last = (pl_ff == plen);
      pl_next = pl_ff - plen;
      k_next  = k_ff + 1'b1;

      frag.kind           = KIND_FU_A;
      frag.slice_offset   = off_ff;
      frag.slice_length   = plen;
      frag.fu_ind_byte    = ind_ff;
      frag.fu_header_byte = {off_ff == LEN_W'(1), is_last, 1'b0, typ_ff};
      frag.marker         = is_last && fend_ff;
      frag.last_of_run    = is_last;

      whole = '0;
      whole.last_of_run = 1'b1;
      if (job.kind == KIND_SINGLE) begin
         whole.kind         = KIND_SINGLE;
         whole.slice_length = job.nal_length;
         whole.marker       = job.fend;
      end else begin
         whole.kind = KIND_ERROR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            out_valid_ff <= 1'b1;
            if (pl_next == '0 || k_next == CNT_W'(MAX_PACKETS)) begin
               busy_ff <= 1'b0;
            end
         end else if (job_pop && job.kind != KIND_FU_A) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (job_pop && job.kind == KIND_FU_A) begin
            busy_ff <= 1'b1;
         end
      end
      if (step) begin
         out_ff <= frag;
         per_ff <= per_eff;
         pl_ff  <= pl_next;
         off_ff <= off_ff + plen;
         num_ff <= (num_ff != '0) ? num_ff - 1'b1 : '0;
         k_ff   <= k_next;
      end else if (job_pop) begin
         out_ff    <= whole;
         pl_ff     <= job.pl;
         per_ff    <= job.per;
         larger_ff <= job.larger;
         num_ff    <= job.num;
         ind_ff    <= job.ind;
         typ_ff    <= job.typ;
         fend_ff   <= job.fend;
         off_ff    <= LEN_W'(1);
         k_ff      <= '0;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.kind           = out_ff.kind;
   assign rsp.slice_offset   = out_ff.slice_offset;
   assign rsp.slice_length   = out_ff.slice_length;
   assign rsp.fu_ind_byte    = out_ff.fu_ind_byte;
   assign rsp.fu_header_byte = out_ff.fu_header_byte;
   assign rsp.marker         = out_ff.marker;
   assign rsp.last_of_run    = out_ff.last_of_run;

endmodule

>>> bench/h264_rtp_packet_planner_tb.sv
// Self-checking testbench for the H.264 RTP packet planner: stimulus, plan prediction and checks.
`timescale 1ns / 1ps

module h264_rtp_packet_planner_tb;
   import h264rtp_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 5;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_NALS  = 72;

   typedef struct packed {
      logic [LEN_W-1:0] nal_length;
      logic [7:0]       nal_header;
      logic             frame_end;
   } nal_desc_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   h264rtp_req_if req_chan ();
   h264rtp_rsp_if rsp_chan ();
   h264rtp_csr_if csr_chan ();

   h264_rtp_packet_planner dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Settings as the predictor sees them; they change only while the block is idle.
   logic [MP_W-1:0]  max_payload_cfg    = MAX_PAYLOAD_RESET;
   logic [RED_W-1:0] last_reduction_cfg = LAST_REDUCTION_RESET;
   logic             non_interleaved    = MODE_RESET;
   logic             dropping_frame     = 1'b0;

   nal_desc_type nal_queue[$];
   result_type   planned_pkts[$];
   nal_desc_type next_nal;
   result_type   got_pkt;
   result_type   want_pkt;
   logic         nal_taken = 1'b0;
   int           send_idle_pct = 0;
   int           rx_stall_pct  = 0;
   int           fail_count    = 0;
   int           pkt_count     = 0;
   int           cycle_count   = 0;

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.nal_length = '0;
      req_chan.nal_header = '0;
      req_chan.frame_end  = 1'b0;
      rsp_chan.ready      = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.index      = CSR_MAX_PAYLOAD;
      csr_chan.data       = '0;
   end

   // Works out the packet plan of one NAL unit and updates the frame drop state.
   task automatic plan_nal(input nal_desc_type nal);
      int unsigned extra, cap, pl, total, num, per, larger, off, plen;
      int          k;
      logic [7:0]  ind;
      logic [7:0]  fh;
      logic        is_last;
      extra = nal.frame_end ? last_reduction_cfg : 0;
      if (dropping_frame) begin
         if (nal.frame_end) dropping_frame = 1'b0;
         return;
      end
      if (nal.nal_length + extra <= max_payload_cfg) begin
         planned_pkts.insert(planned_pkts.size(),
                             result_type'{KIND_SINGLE, '0, nal.nal_length, 8'd0, 8'd0,
                                          nal.frame_end, 1'b1});
         return;
      end
      cap = (max_payload_cfg > FU_OVERHEAD) ? max_payload_cfg - FU_OVERHEAD : 0;
      pl  = (nal.nal_length > 1) ? nal.nal_length - 1 : 0;
      total = pl + extra;
      num = (cap == 0) ? 0 : (total + cap - 1) / cap;
      if (!non_interleaved || cap == 0 || pl == 0 || num > PKT_DEFAULT) begin
         planned_pkts.insert(planned_pkts.size(),
                             result_type'{KIND_ERROR, '0, '0, 8'd0, 8'd0, 1'b0, 1'b1});
         dropping_frame = !nal.frame_end;
         return;
      end
      per    = total / num;
      larger = total % num;
      ind    = (nal.nal_header & 8'hE0) | FU_A_TYPE;
      off    = 1;
      k      = 0;
      while (pl > 0 && k < PKT_DEFAULT) begin
         // The last fragments, as many as the remainder, carry one byte more than the rest.
         if (num == larger) per++;
         plen = per;
         if (pl <= plen) begin
            plen = pl;
            if (num == 2) plen--;
         end
         is_last = (pl == plen);
         fh = {off == 1, is_last, 1'b0, nal.nal_header[4:0]};
         planned_pkts.insert(planned_pkts.size(),
                             result_type'{KIND_FU_A, off[LEN_W-1:0], plen[LEN_W-1:0], ind,
                                          fh, is_last & nal.frame_end, is_last});
         k++;
         off += plen;
         pl  -= plen;
         if (num > 0) num--;
      end
   endtask

   task automatic flag_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("packet %0d: %s expected %0d, got %0d", pkt_count, field, want, got);
   endtask

   // Sender side: a new descriptor is offered only once the previous one was transferred.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (!req_chan.valid || nal_taken) begin
            if (nal_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_nal = nal_queue[0];
               nal_queue.delete(0);
               req_chan.valid      <= 1'b1;
               req_chan.nal_length <= next_nal.nal_length;
               req_chan.nal_header <= next_nal.nal_header;
               req_chan.frame_end  <= next_nal.frame_end;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Observer: predicts on each descriptor transfer and checks each packet transfer.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      nal_taken   <= req_chan.valid && req_chan.ready && !reset;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            plan_nal('{req_chan.nal_length, req_chan.nal_header, req_chan.frame_end});
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_pkt = '{kind_type'(rsp_chan.kind), rsp_chan.slice_offset,
                        rsp_chan.slice_length, rsp_chan.fu_ind_byte,
                        rsp_chan.fu_header_byte, rsp_chan.marker, rsp_chan.last_of_run};
            if (planned_pkts.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("packet %0d arrived with none planned: kind %0d offset %0d len %0d",
                           pkt_count, got_pkt.kind, got_pkt.slice_offset,
                           got_pkt.slice_length);
            end else begin
               want_pkt = planned_pkts[0];
               planned_pkts.delete(0);
               if (got_pkt.kind !== want_pkt.kind)
                  flag_field("kind", want_pkt.kind, got_pkt.kind);
               if (got_pkt.slice_offset !== want_pkt.slice_offset)
                  flag_field("slice_offset", want_pkt.slice_offset, got_pkt.slice_offset);
               if (got_pkt.slice_length !== want_pkt.slice_length)
                  flag_field("slice_length", want_pkt.slice_length, got_pkt.slice_length);
               if (got_pkt.fu_ind_byte !== want_pkt.fu_ind_byte)
                  flag_field("fu_ind_byte", want_pkt.fu_ind_byte, got_pkt.fu_ind_byte);
               if (got_pkt.fu_header_byte !== want_pkt.fu_header_byte)
                  flag_field("fu_header_byte", want_pkt.fu_header_byte,
                             got_pkt.fu_header_byte);
               if (got_pkt.marker !== want_pkt.marker)
                  flag_field("marker", want_pkt.marker, got_pkt.marker);
               if (got_pkt.last_of_run !== want_pkt.last_of_run)
                  flag_field("last_of_run", want_pkt.last_of_run, got_pkt.last_of_run);
            end
            pkt_count++;
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("h264_rtp_packet_planner regression: fail");
      $finish;
   end

   task automatic queue_nal(input int len, input int hdr, input bit fend);
      nal_queue.insert(nal_queue.size(), nal_desc_type'{len[LEN_W-1:0], hdr[7:0], fend});
   endtask

   // Waits until every descriptor is transferred and every planned packet has come,
   // then lets dropped descriptors still in the pipeline work their way out.
   task automatic wait_idle();
      while (nal_queue.size() != 0 || req_chan.valid || planned_pkts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (idx)
         CSR_MAX_PAYLOAD:    max_payload_cfg    = value[MP_W-1:0];
         CSR_LAST_REDUCTION: last_reduction_cfg = value[RED_W-1:0];
         CSR_MODE:           non_interleaved    = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic set_config(input int mp, input int red, input int mode);
      write_reg(CSR_MAX_PAYLOAD, mp);
      write_reg(CSR_LAST_REDUCTION, red);
      write_reg(CSR_MODE, mode);
   endtask

   // Lengths cluster around the payload limit, where the fit decision flips.
   function automatic int pick_length(input int mp);
      int r, lo, hi;
      r = $urandom_range(99);
      if (r < 35) return $urandom_range(mp, 1);
      if (r < 65) begin
         lo = (mp > 70) ? mp - 70 : 1;
         return $urandom_range(mp + 70, lo);
      end
      if (r < 90) begin
         hi = (4 * mp > 16383) ? 16383 : 4 * mp;
         return $urandom_range(hi, 1);
      end
      return $urandom_range(16383, 1);
   endfunction

   task automatic queue_random(input int count);
      repeat (count)
         queue_nal(pick_length(max_payload_cfg), $urandom_range(255),
                   $urandom_range(99) < 35);
   endtask

   task automatic run_phase(input int mp, input int red, input int mode,
                            input int idle_pct, input int stall_pct);
      wait_idle();
      set_config(mp, red, mode);
      send_idle_pct = idle_pct;
      rx_stall_pct  = stall_pct;
      queue_random(RANDOM_NALS);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: exact fit, two fragments, the longest NAL unit, bit patterns.
      queue_nal(1, 8'h00, 1);
      queue_nal(1200, 8'hFF, 0);
      queue_nal(1201, 8'h65, 1);
      queue_nal(16383, 8'hE7, 1);
      queue_nal(8191, 8'h1C, 0);
      queue_nal(2400, 8'h41, 1);
      queue_nal(10922, 8'hAA, 0);
      queue_nal(5461, 8'h55, 1);
      wait_idle();

      // Smallest payload with the largest reduction: up to the full 64 fragments.
      set_config(260, 64, 1);
      queue_nal(16383, 8'h7C, 1);
      queue_nal(16383, 8'h9F, 0);
      queue_nal(196, 8'h00, 1);
      queue_nal(197, 8'h21, 1);
      queue_nal(260, 8'h33, 0);
      queue_nal(261, 8'h33, 0);
      wait_idle();

      // Single NAL unit mode: errors, and dropping the rest of a frame after one.
      set_config(4096, 64, 0);
      queue_nal(4032, 8'h61, 1);
      queue_nal(4033, 8'h61, 1);
      queue_nal(4096, 8'h05, 0);
      queue_nal(5000, 8'h05, 0);
      queue_nal(10, 8'h01, 0);
      queue_nal(20, 8'h01, 1);
      queue_nal(30, 8'h01, 1);
      queue_nal(16383, 8'hFF, 0);
      queue_nal(1, 8'h00, 1);
      queue_nal(4097, 8'h02, 1);

      run_phase(260, 64, 1, 68, 0);
      run_phase(4096, 0, 1, 0, 68);
      run_phase($urandom_range(4096, 260), $urandom_range(64, 0), 0, 33, 33);
      run_phase($urandom_range(4096, 260), $urandom_range(64, 0), 1, 0, 0);
      // The sender holds off here until the first half has fully drained.
      wait_idle();
      queue_random(RANDOM_NALS / 2);
      run_phase($urandom_range(4096, 260), $urandom_range(64, 0), $urandom_range(1, 0),
                68, 0);
      run_phase(1200, $urandom_range(64, 0), 1, 33, 33);
      wait_idle();

      if (fail_count == 0)
         $display("h264_rtp_packet_planner regression: pass");
      else
         $display("h264_rtp_packet_planner regression: fail");
      $finish;
   end

endmodule
